/* hw/rtl/csw_pkg.sv */
// ----------------------------------------------------------------------------
// csw_pkg: shared types and constants of the clock setup wizard
// Phase and event codes, the wizard state word and the month length lookup.
// ----------------------------------------------------------------------------
package csw_pkg;

	// Phase codes
	localparam logic [3:0] PH_BOOT   = 4'd0;
	localparam logic [3:0] PH_HELLO  = 4'd1;
	localparam logic [3:0] PH_TIME   = 4'd2;
	localparam logic [3:0] PH_DAY    = 4'd3;
	localparam logic [3:0] PH_MONTH  = 4'd4;
	localparam logic [3:0] PH_YEAR   = 4'd5;
	localparam logic [3:0] PH_HOUR   = 4'd6;
	localparam logic [3:0] PH_MINUTE = 4'd7;
	localparam logic [3:0] PH_DONE   = 4'd8;

	// Event codes
	localparam logic [2:0] FN_TICK = 3'd0;
	localparam logic [2:0] FN_ENC  = 3'd1;
	localparam logic [2:0] FN_TOP  = 3'd2;
	localparam logic [2:0] FN_BACK = 3'd3;
	localparam logic [2:0] FN_INIT = 3'd4;

	// Configuration register indexes
	localparam logic CFG_BLINK = 1'b0;
	localparam logic CFG_ANIM  = 1'b1;

	// Reset values and field limits
	localparam logic [15:0] BLINK_RST   = 16'd250;
	localparam logic [15:0] ANIM_RST    = 16'd83;
	localparam logic [2:0]  FRAME_LAST  = 3'd5;
	localparam logic [3:0]  MONTH_TOP   = 4'd12;
	localparam logic [6:0]  YEAR_TOP    = 7'd99;
	localparam logic [6:0]  YEAR_START  = 7'd25;
	localparam logic [4:0]  HOUR_TOP    = 5'd23;
	localparam logic [5:0]  MINUTE_TOP  = 6'd59;
	localparam logic [3:0]  MASK_ALL    = 4'hF;
	localparam logic [3:0]  MASK_LEFT   = 4'h3;
	localparam logic [3:0]  MASK_RIGHT  = 4'hC;

	typedef struct packed {
		logic [3:0]  phase;
		logic [31:0] last_time;
		logic [2:0]  frame;
		logic [6:0]  year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [3:0]  mask;
		logic        led;
		logic        dots;
	} wiz_state_t;

	// Wizard state after reset: boot phase, all digits visible
	localparam wiz_state_t WIZ_RST = '{
		phase: PH_BOOT, last_time: 32'd0, frame: 3'd0, year: 7'd0, month: 4'd0,
		day: 5'd0, hour: 5'd0, minute: 6'd0, mask: MASK_ALL, led: 1'b0, dots: 1'b0
	};

	typedef struct packed {
		wiz_state_t nxt;
		logic       commit;
		logic       beep;
	} step_res_t;

	// Month length; out-of-range months count as 31 days
	function automatic logic [4:0] days_in(input logic [3:0] month, input logic [6:0] year);
		logic [4:0] len;
		begin
			case (month)
				4'd2:    len = (year[1:0] == 2'd0) ? 5'd29 : 5'd28;
				4'd4:    len = 5'd30;
				4'd6:    len = 5'd30;
				4'd9:    len = 5'd30;
				4'd11:   len = 5'd30;
				default: len = 5'd31;
			endcase
			return len;
		end
	endfunction

endpackage

/* hw/rtl/csw_step.sv */
// ----------------------------------------------------------------------------
// csw_step: next-state logic of the clock setup wizard
// Applies one event word to the wizard state and flags commit and beep.
// ----------------------------------------------------------------------------
module csw_step (
	input  csw_pkg::wiz_state_t cur,
	input  logic [15:0]         blink_period,
	input  logic [15:0]         anim_period,
	input  logic [2:0]          func,
	input  logic [31:0]         now_ms,
	input  logic                clockwise,
	input  logic                already_set,
	output csw_pkg::step_res_t  res
);

	logic [31:0] elapsed;
	logic        anim_due;
	logic        blink_due;
	logic [4:0]  day_lim;
	logic [3:0]  month_step;
	logic [4:0]  month_lim;

	// Time since the last timer action, modulo 2^32
	assign elapsed   = now_ms - cur.last_time;
	assign anim_due  = elapsed >= {16'd0, anim_period};
	assign blink_due = elapsed > {16'd0, blink_period};

	// Day limit for the current month and for the stepped month
	assign day_lim = csw_pkg::days_in(cur.month, cur.year);
	always_comb begin
		if (clockwise) begin
			month_step = (cur.month >= csw_pkg::MONTH_TOP) ? 4'd1 : cur.month + 4'd1;
		end else begin
			month_step = (cur.month <= 4'd1) ? csw_pkg::MONTH_TOP : cur.month - 4'd1;
		end
	end
	assign month_lim = csw_pkg::days_in(month_step, cur.year);

	// Dispatch the event
	always_comb begin
		res        = '0;
		res.nxt    = cur;
		if (func == csw_pkg::FN_INIT) begin
			res.nxt.led = 1'b1;
			if (already_set) begin
				res.nxt.phase = csw_pkg::PH_DONE;
			end else begin
				res.nxt.phase = csw_pkg::PH_HELLO;
				res.nxt.dots  = 1'b1;
			end
		end else if (cur.phase != csw_pkg::PH_DONE) begin
			case (func)
				csw_pkg::FN_TICK: begin
					case (cur.phase)
						csw_pkg::PH_BOOT: begin
							if (anim_due) begin
								res.nxt.last_time = now_ms;
								res.nxt.frame = (cur.frame >= csw_pkg::FRAME_LAST) ?
									3'd0 : cur.frame + 3'd1;
							end
						end
						csw_pkg::PH_HELLO: begin
							if (blink_due) begin
								res.nxt.last_time = now_ms;
								res.nxt.led = ~cur.led;
							end
						end
						csw_pkg::PH_DAY, csw_pkg::PH_HOUR: begin
							if (blink_due) begin
								res.nxt.last_time = now_ms;
								res.nxt.mask = cur.mask ^ csw_pkg::MASK_LEFT;
							end
						end
						csw_pkg::PH_MONTH, csw_pkg::PH_MINUTE: begin
							if (blink_due) begin
								res.nxt.last_time = now_ms;
								res.nxt.mask = cur.mask ^ csw_pkg::MASK_RIGHT;
							end
						end
						default: ;
					endcase
				end
				csw_pkg::FN_ENC: begin
					res.beep = 1'b1;
					case (cur.phase)
						csw_pkg::PH_DAY: begin
							if (clockwise) begin
								res.nxt.day = (cur.day >= day_lim) ? 5'd1 : cur.day + 5'd1;
							end else begin
								res.nxt.day = (cur.day <= 5'd1) ? day_lim : cur.day - 5'd1;
							end
						end
						csw_pkg::PH_MONTH: begin
							res.nxt.month = month_step;
							if (cur.day > month_lim) begin
								res.nxt.day = month_lim;
							end
						end
						csw_pkg::PH_YEAR: begin
							if (clockwise) begin
								res.nxt.year = (cur.year >= csw_pkg::YEAR_TOP) ?
									7'd0 : cur.year + 7'd1;
							end else begin
								res.nxt.year = (cur.year == 7'd0) ?
									csw_pkg::YEAR_TOP : cur.year - 7'd1;
							end
						end
						csw_pkg::PH_HOUR: begin
							if (clockwise) begin
								res.nxt.hour = (cur.hour >= csw_pkg::HOUR_TOP) ?
									5'd0 : cur.hour + 5'd1;
							end else begin
								res.nxt.hour = (cur.hour == 5'd0) ?
									csw_pkg::HOUR_TOP : cur.hour - 5'd1;
							end
						end
						csw_pkg::PH_MINUTE: begin
							if (clockwise) begin
								res.nxt.minute = (cur.minute >= csw_pkg::MINUTE_TOP) ?
									6'd0 : cur.minute + 6'd1;
							end else begin
								res.nxt.minute = (cur.minute == 6'd0) ?
									csw_pkg::MINUTE_TOP : cur.minute - 6'd1;
							end
						end
						default: ;
					endcase
				end
				csw_pkg::FN_TOP: begin
					res.beep = 1'b1;
					case (cur.phase)
						csw_pkg::PH_HELLO: begin
							res.nxt.phase = csw_pkg::PH_YEAR;
							res.nxt.mask  = csw_pkg::MASK_ALL;
							res.nxt.dots  = 1'b0;
							res.nxt.led   = 1'b1;
							res.nxt.year  = csw_pkg::YEAR_START;
						end
						csw_pkg::PH_YEAR: begin
							res.nxt.phase = csw_pkg::PH_DAY;
							res.nxt.day   = 5'd1;
							res.nxt.month = 4'd1;
							res.nxt.mask  = csw_pkg::MASK_ALL;
							res.nxt.dots  = 1'b1;
							res.nxt.led   = 1'b1;
						end
						csw_pkg::PH_DAY, csw_pkg::PH_MONTH: begin
							res.nxt.phase  = csw_pkg::PH_HOUR;
							res.nxt.hour   = 5'd0;
							res.nxt.minute = 6'd0;
							res.nxt.mask   = csw_pkg::MASK_ALL;
							res.nxt.dots   = 1'b1;
							res.nxt.led    = 1'b1;
						end
						csw_pkg::PH_HOUR, csw_pkg::PH_MINUTE: begin
							res.commit    = 1'b1;
							res.nxt.phase = csw_pkg::PH_DONE;
						end
						default: ;
					endcase
				end
				csw_pkg::FN_BACK: begin
					res.beep = 1'b1;
					case (cur.phase)
						csw_pkg::PH_DAY: begin
							res.nxt.mask  = csw_pkg::MASK_ALL;
							res.nxt.phase = csw_pkg::PH_MONTH;
						end
						csw_pkg::PH_MONTH: begin
							res.nxt.mask  = csw_pkg::MASK_ALL;
							res.nxt.phase = csw_pkg::PH_DAY;
						end
						csw_pkg::PH_HOUR: begin
							res.nxt.mask  = csw_pkg::MASK_ALL;
							res.nxt.phase = csw_pkg::PH_MINUTE;
						end
						csw_pkg::PH_MINUTE: begin
							res.nxt.mask  = csw_pkg::MASK_ALL;
							res.nxt.phase = csw_pkg::PH_HOUR;
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

endmodule

/* hw/rtl/clock_setup_wizard_fsm_unit.sv */
// ----------------------------------------------------------------------------
// clock_setup_wizard_fsm_unit: first-power-up setup wizard of a 4-digit clock
// Input register, one pass of next-state logic, result register.
// ----------------------------------------------------------------------------
// Usage:
//   Event words (func, now_ms, clockwise, already_set) enter on in_valid and
//   are taken at an edge where in_valid is high and in_stall is low. Each
//   event gives exactly one result word on out_valid, taken at an edge where
//   out_stall is low. Results keep event order.
//   A taken word passes the input register and then the result register,
//   which presents it on the result port.
//   Throughput: one word per cycle while out_stall is low; the wizard state
//   is updated in the same cycle that a word moves into the result register,
//   so the next word sees it without any bubble.
//   When the receiver stalls, the result register holds its word and the
//   input register holds one more; in_stall rises once both are full.
//   Reset empties both registers, puts the wizard in the boot phase with all
//   digits visible and loads blink 250 ms and animation 83 ms periods.
//   cfg_we writes cfg_data to register cfg_index (0 blink, 1 animation);
//   write only while no word is in flight.
// ----------------------------------------------------------------------------
module clock_setup_wizard_fsm_unit (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	// Event channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  func,
	input  logic [31:0] now_ms,
	input  logic        clockwise,
	input  logic        already_set,
	// Result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  phase,
	output logic [6:0]  year_val,
	output logic [3:0]  month_val,
	output logic [4:0]  day_val,
	output logic [4:0]  hour_val,
	output logic [5:0]  minute_val,
	output logic [3:0]  digit_visible,
	output logic [2:0]  anim_frame,
	output logic        led_on,
	output logic        dots_on,
	output logic        commit,
	output logic        beep
);

	logic [15:0]         blink_period_q;
	logic [15:0]         anim_period_q;
	csw_pkg::wiz_state_t state_q;
	csw_pkg::step_res_t  step;

	logic        valid_s1;
	logic [2:0]  func_s1;
	logic [31:0] now_s1;
	logic        cw_s1;
	logic        set_s1;

	logic        valid_s2;
	logic [3:0]  phase_s2;
	logic [6:0]  year_s2;
	logic [3:0]  month_s2;
	logic [4:0]  day_s2;
	logic [4:0]  hour_s2;
	logic [5:0]  minute_s2;
	logic [3:0]  mask_s2;
	logic [2:0]  frame_s2;
	logic        led_s2;
	logic        dots_s2;
	logic        commit_s2;
	logic        beep_s2;

	logic s2_free;
	logic adv;
	logic in_acc;

	// Handshake
	assign s2_free  = ~valid_s2 | ~out_stall;
	assign adv      = valid_s1 & s2_free;
	assign in_stall = valid_s1 & ~s2_free;
	assign in_acc   = in_valid & ~in_stall;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_period_q <= csw_pkg::BLINK_RST;
			anim_period_q  <= csw_pkg::ANIM_RST;
		end else if (cfg_we) begin
			if (cfg_index == csw_pkg::CFG_BLINK) begin
				blink_period_q <= cfg_data;
			end else begin
				anim_period_q <= cfg_data;
			end
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_s1 <= func;
			now_s1  <= now_ms;
			cw_s1   <= clockwise;
			set_s1  <= already_set;
		end
	end

	// Next-state logic
	csw_step u_step (
		.cur          (state_q),
		.blink_period (blink_period_q),
		.anim_period  (anim_period_q),
		.func         (func_s1),
		.now_ms       (now_s1),
		.clockwise    (cw_s1),
		.already_set  (set_s1),
		.res          (step)
	);

	// Wizard state: advance when a word moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= csw_pkg::WIZ_RST;
		end else if (adv) begin
			state_q <= step.nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (~out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			phase_s2  <= step.nxt.phase;
			year_s2   <= step.nxt.year;
			month_s2  <= step.nxt.month;
			day_s2    <= step.nxt.day;
			hour_s2   <= step.nxt.hour;
			minute_s2 <= step.nxt.minute;
			mask_s2   <= step.nxt.mask;
			frame_s2  <= (step.nxt.frame == 3'd0) ? csw_pkg::FRAME_LAST :
				step.nxt.frame - 3'd1;
			led_s2    <= step.nxt.led;
			dots_s2   <= step.nxt.dots;
			commit_s2 <= step.commit;
			beep_s2   <= step.beep;
		end
	end

	// Drive outputs
	assign out_valid     = valid_s2;
	assign phase         = phase_s2;
	assign year_val      = year_s2;
	assign month_val     = month_s2;
	assign day_val       = day_s2;
	assign hour_val      = hour_s2;
	assign minute_val    = minute_s2;
	assign digit_visible = mask_s2;
	assign anim_frame    = frame_s2;
	assign led_on        = led_s2;
	assign dots_on       = dots_s2;
	assign commit        = commit_s2;
	assign beep          = beep_s2;

`ifndef SYNTH
	a_commit_done: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && commit_s2) |-> (phase_s2 == csw_pkg::PH_DONE && beep_s2))
		else $error("commit without hand-off");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(state_q))
		else $error("wizard state changed without a word");

	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> !in_stall)
		else $error("input stalled with empty result register");

	a_frame_range: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (frame_s2 <= csw_pkg::FRAME_LAST && state_q.frame <= csw_pkg::FRAME_LAST))
		else $error("animation frame out of range");
`endif

endmodule

/* tb/tb_clock_setup_wizard_fsm_unit.sv */
// ----------------------------------------------------------------------------
// tb_clock_setup_wizard_fsm_unit: self-checking bench of the clock setup wizard
// Walks a short table of events through boot, hello, year, date and time
// entry, then drives random setup sessions under several period settings.
// A predictor tracks the wizard state, and every result word is compared
// field by field. Sender bursts and receiver stalls vary at random.
// ----------------------------------------------------------------------------
module tb_clock_setup_wizard_fsm_unit;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned WORDS_PER_SETTING = 110;

	typedef struct packed {
		logic [2:0]  func;
		logic [31:0] ms;
		logic        cw;
		logic        set_before;
	} evt_t;

	typedef struct packed {
		logic [3:0] phase;
		logic [6:0] year_val;
		logic [3:0] month_val;
		logic [4:0] day_val;
		logic [4:0] hour_val;
		logic [5:0] minute_val;
		logic [3:0] digit_visible;
		logic [2:0] anim_frame;
		logic       led_on;
		logic       dots_on;
		logic       commit;
		logic       beep;
	} screen_t;

	typedef struct packed {
		bit          is_cfg;
		logic        cfg_idx;
		logic [15:0] cfg_val;
		evt_t        ev;
		bit          at_reset;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [15:0] cfg_data = 16'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  func = 3'd0;
	logic [31:0] now_ms = 32'd0;
	logic        clockwise = 1'b0;
	logic        already_set = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [3:0]  phase;
	logic [6:0]  year_val;
	logic [3:0]  month_val;
	logic [4:0]  day_val;
	logic [4:0]  hour_val;
	logic [5:0]  minute_val;
	logic [3:0]  digit_visible;
	logic [2:0]  anim_frame;
	logic        led_on;
	logic        dots_on;
	logic        commit;
	logic        beep;

	clock_setup_wizard_fsm_unit uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .now_ms(now_ms), .clockwise(clockwise), .already_set(already_set),
		.out_valid(out_valid), .out_stall(out_stall),
		.phase(phase), .year_val(year_val), .month_val(month_val), .day_val(day_val),
		.hour_val(hour_val), .minute_val(minute_val), .digit_visible(digit_visible),
		.anim_frame(anim_frame), .led_on(led_on), .dots_on(dots_on),
		.commit(commit), .beep(beep)
	);

	// Predicted wizard state and periods
	csw_pkg::wiz_state_t wiz;
	logic [15:0] blink_ms;
	logic [15:0] anim_ms;
	screen_t     reset_screen;

	screen_t     pending_screens[$];
	row_t        directed_rows[$];
	int unsigned errors = 0;
	int unsigned cycles = 0;

	// Random session shaping
	logic [31:0] wall_ms = 32'd0;
	logic [3:0]  seen_phase = csw_pkg::PH_BOOT;
	int unsigned steps_left = 0;
	logic        turn_cw = 1'b1;
	int unsigned burst_left = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL clock_setup_wizard_fsm_unit");
			$finish;
		end
	end

	function automatic logic [4:0] month_days(input logic [3:0] m, input logic [6:0] y);
		if (m < 4'd1 || m > csw_pkg::MONTH_TOP) return 5'd31;
		if (m == 4'd2) return (y % 7'd4 == 7'd0) ? 5'd29 : 5'd28;
		if (m == 4'd4 || m == 4'd6 || m == 4'd9 || m == 4'd11) return 5'd30;
		return 5'd31;
	endfunction

	function automatic logic [7:0] wrap_step(input logic [7:0] v, input logic [7:0] lo,
			input logic [7:0] hi, input logic up);
		if (up) return (v >= hi) ? lo : v + 8'd1;
		return (v <= lo) ? hi : v - 8'd1;
	endfunction

	// Apply one event to the predicted state and form the expected screen
	task automatic advance_wizard(input evt_t ev, output screen_t scr);
		logic [31:0] elapsed;
		logic [4:0]  lim;
		logic        done_flag;
		logic        beeped;
		elapsed = ev.ms - wiz.last_time;
		done_flag = 1'b0;
		beeped = 1'b0;
		if (ev.func == csw_pkg::FN_INIT) begin
			wiz.led = 1'b1;
			if (ev.set_before) begin
				wiz.phase = csw_pkg::PH_DONE;
			end else begin
				wiz.phase = csw_pkg::PH_HELLO;
				wiz.dots = 1'b1;
			end
		end else if (wiz.phase != csw_pkg::PH_DONE && ev.func <= csw_pkg::FN_BACK) begin
			beeped = (ev.func != csw_pkg::FN_TICK);
			case (ev.func)
				csw_pkg::FN_TICK: begin
					case (wiz.phase)
						csw_pkg::PH_BOOT: begin
							if (elapsed >= 32'(anim_ms)) begin
								wiz.last_time = ev.ms;
								wiz.frame = (wiz.frame >= csw_pkg::FRAME_LAST) ?
									3'd0 : wiz.frame + 3'd1;
							end
						end
						csw_pkg::PH_HELLO: begin
							if (elapsed > 32'(blink_ms)) begin
								wiz.last_time = ev.ms;
								wiz.led = ~wiz.led;
							end
						end
						csw_pkg::PH_DAY, csw_pkg::PH_HOUR: begin
							if (elapsed > 32'(blink_ms)) begin
								wiz.last_time = ev.ms;
								wiz.mask = wiz.mask ^ csw_pkg::MASK_LEFT;
							end
						end
						csw_pkg::PH_MONTH, csw_pkg::PH_MINUTE: begin
							if (elapsed > 32'(blink_ms)) begin
								wiz.last_time = ev.ms;
								wiz.mask = wiz.mask ^ csw_pkg::MASK_RIGHT;
							end
						end
						default: ;
					endcase
				end
				csw_pkg::FN_ENC: begin
					case (wiz.phase)
						csw_pkg::PH_DAY: begin
							lim = month_days(wiz.month, wiz.year);
							wiz.day = 5'(wrap_step(8'(wiz.day), 8'd1, 8'(lim), ev.cw));
						end
						csw_pkg::PH_MONTH: begin
							wiz.month = 4'(wrap_step(8'(wiz.month), 8'd1,
								8'(csw_pkg::MONTH_TOP), ev.cw));
							lim = month_days(wiz.month, wiz.year);
							if (wiz.day > lim) wiz.day = lim;
						end
						csw_pkg::PH_YEAR: begin
							wiz.year = 7'(wrap_step(8'(wiz.year), 8'd0,
								8'(csw_pkg::YEAR_TOP), ev.cw));
						end
						csw_pkg::PH_HOUR: begin
							wiz.hour = 5'(wrap_step(8'(wiz.hour), 8'd0,
								8'(csw_pkg::HOUR_TOP), ev.cw));
						end
						csw_pkg::PH_MINUTE: begin
							wiz.minute = 6'(wrap_step(8'(wiz.minute), 8'd0,
								8'(csw_pkg::MINUTE_TOP), ev.cw));
						end
						default: ;
					endcase
				end
				csw_pkg::FN_TOP: begin
					case (wiz.phase)
						csw_pkg::PH_HELLO: begin
							wiz.phase = csw_pkg::PH_YEAR;
							wiz.mask = csw_pkg::MASK_ALL;
							wiz.dots = 1'b0;
							wiz.led = 1'b1;
							wiz.year = csw_pkg::YEAR_START;
						end
						csw_pkg::PH_YEAR: begin
							wiz.phase = csw_pkg::PH_DAY;
							wiz.day = 5'd1;
							wiz.month = 4'd1;
							wiz.mask = csw_pkg::MASK_ALL;
							wiz.dots = 1'b1;
							wiz.led = 1'b1;
						end
						csw_pkg::PH_DAY, csw_pkg::PH_MONTH: begin
							wiz.phase = csw_pkg::PH_HOUR;
							wiz.hour = 5'd0;
							wiz.minute = 6'd0;
							wiz.mask = csw_pkg::MASK_ALL;
							wiz.dots = 1'b1;
							wiz.led = 1'b1;
						end
						csw_pkg::PH_HOUR, csw_pkg::PH_MINUTE: begin
							done_flag = 1'b1;
							wiz.phase = csw_pkg::PH_DONE;
						end
						default: ;
					endcase
				end
				default: begin
					// back button toggles between the two fields of a page
					wiz.mask = (wiz.phase == csw_pkg::PH_DAY || wiz.phase == csw_pkg::PH_MONTH ||
						wiz.phase == csw_pkg::PH_HOUR || wiz.phase == csw_pkg::PH_MINUTE) ?
						csw_pkg::MASK_ALL : wiz.mask;
					case (wiz.phase)
						csw_pkg::PH_DAY: wiz.phase = csw_pkg::PH_MONTH;
						csw_pkg::PH_MONTH: wiz.phase = csw_pkg::PH_DAY;
						csw_pkg::PH_HOUR: wiz.phase = csw_pkg::PH_MINUTE;
						csw_pkg::PH_MINUTE: wiz.phase = csw_pkg::PH_HOUR;
						default: ;
					endcase
				end
			endcase
		end
		scr.phase = wiz.phase;
		scr.year_val = wiz.year;
		scr.month_val = wiz.month;
		scr.day_val = wiz.day;
		scr.hour_val = wiz.hour;
		scr.minute_val = wiz.minute;
		scr.digit_visible = wiz.mask;
		scr.anim_frame = (wiz.frame == 3'd0) ? csw_pkg::FRAME_LAST : wiz.frame - 3'd1;
		scr.led_on = wiz.led;
		scr.dots_on = wiz.dots;
		scr.commit = done_flag;
		scr.beep = beeped;
	endtask

	// Offer one event word, record its expectation once taken, then pace the sender
	task automatic offer_word(input evt_t ev, input bit at_reset);
		screen_t scr;
		func <= ev.func;
		now_ms <= ev.ms;
		clockwise <= ev.cw;
		already_set <= ev.set_before;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		advance_wizard(ev, scr);
		pending_screens.push_back(at_reset ? reset_screen : scr);
		if (burst_left != 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ?
				$urandom_range(20, 40) : $urandom_range(0, 6);
		end
	endtask

	// Drain the block, then write one period register
	task automatic write_reg(input logic idx, input logic [15:0] val);
		in_valid <= 1'b0;
		while (pending_screens.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == csw_pkg::CFG_BLINK) blink_ms = val;
		else anim_ms = val;
	endtask

	task automatic add_word(input logic [2:0] f, input logic [31:0] ms, input logic cw,
			input logic sb, input bit at_reset);
		row_t rw;
		rw = '0;
		rw.ev.func = f;
		rw.ev.ms = ms;
		rw.ev.cw = cw;
		rw.ev.set_before = sb;
		rw.at_reset = at_reset;
		directed_rows.push_back(rw);
	endtask

	task automatic add_write(input logic idx, input logic [15:0] val);
		row_t rw;
		rw = '0;
		rw.is_cfg = 1'b1;
		rw.cfg_idx = idx;
		rw.cfg_val = val;
		directed_rows.push_back(rw);
	endtask

	// Mostly walk a well-formed setup session, with broken steps and noise mixed in
	task automatic pick_event(output evt_t ev);
		int unsigned r;
		ev.func = csw_pkg::FN_TICK;
		ev.ms = $urandom();
		ev.cw = 1'($urandom_range(0, 1));
		ev.set_before = 1'b0;
		if (wiz.phase != seen_phase) begin
			seen_phase = wiz.phase;
			steps_left = ($urandom_range(0, 5) == 0) ?
				$urandom_range(10, 100) : $urandom_range(0, 4);
			turn_cw = 1'($urandom_range(0, 1));
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			ev.func = 3'($urandom_range(0, 7));
			ev.set_before = 1'($urandom_range(0, 1));
		end else if (wiz.phase == csw_pkg::PH_DONE) begin
			ev.func = csw_pkg::FN_INIT;
			ev.set_before = (r < 12);
		end else if (r < 6) begin
			ev.func = csw_pkg::FN_INIT;
			ev.set_before = 1'($urandom_range(0, 1));
		end else if (r < 30) begin
			r = $urandom_range(0, 99);
			if (r < 3) wall_ms = $urandom();
			else if (r < 10) wall_ms = wall_ms + $urandom_range(0, 131071);
			else if (r >= 20) wall_ms = wall_ms + $urandom_range(0, 400);
			ev.ms = wall_ms;
		end else if (steps_left != 0) begin
			ev.func = csw_pkg::FN_ENC;
			ev.cw = (r < 34) ? ~turn_cw : turn_cw;
			steps_left--;
		end else if (r < 55 && (wiz.phase == csw_pkg::PH_DAY ||
				wiz.phase == csw_pkg::PH_MONTH || wiz.phase == csw_pkg::PH_HOUR ||
				wiz.phase == csw_pkg::PH_MINUTE)) begin
			ev.func = csw_pkg::FN_BACK;
		end else begin
			ev.func = csw_pkg::FN_TOP;
		end
	endtask

	task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// Take result words, check them, and stall on a pattern of our own
	always @(posedge clk) begin : rx_side
		screen_t     want;
		bit          stall_next;
		int unsigned rx_tick;
		int unsigned rx_mode;
		int unsigned hold_left;
		int unsigned screens_seen;
		bit          squeezed;
		if (out_valid === 1'b1 && !out_stall) begin
			screens_seen++;
			if (pending_screens.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				want = pending_screens.pop_front();
				cmp_field("phase", 32'(want.phase), 32'(phase));
				cmp_field("year_val", 32'(want.year_val), 32'(year_val));
				cmp_field("month_val", 32'(want.month_val), 32'(month_val));
				cmp_field("day_val", 32'(want.day_val), 32'(day_val));
				cmp_field("hour_val", 32'(want.hour_val), 32'(hour_val));
				cmp_field("minute_val", 32'(want.minute_val), 32'(minute_val));
				cmp_field("digit_visible", 32'(want.digit_visible), 32'(digit_visible));
				cmp_field("anim_frame", 32'(want.anim_frame), 32'(anim_frame));
				cmp_field("led_on", 32'(want.led_on), 32'(led_on));
				cmp_field("dots_on", 32'(want.dots_on), 32'(dots_on));
				cmp_field("commit", 32'(want.commit), 32'(commit));
				cmp_field("beep", 32'(want.beep), 32'(beep));
			end
		end
		rx_tick++;
		if (rx_tick % 37 == 0) rx_mode = $urandom_range(0, 3);
		if (hold_left != 0) begin
			// long hold-off: let the block fill up and push back on the sender
			hold_left--;
			stall_next = 1'b1;
		end else if (!squeezed && screens_seen >= 200) begin
			squeezed = 1'b1;
			hold_left = 80;
			stall_next = 1'b1;
		end else begin
			case (rx_mode)
				0: stall_next = 1'b0;
				1: stall_next = ($urandom_range(0, 3) == 0);
				2: stall_next = ($urandom_range(0, 3) != 0);
				default: stall_next = rx_tick[1];
			endcase
		end
		out_stall <= stall_next;
	end

	initial begin : main_seq
		evt_t        ev;
		row_t        rw;
		int unsigned useful;
		wiz = '0;
		wiz.phase = csw_pkg::PH_BOOT;
		wiz.mask = csw_pkg::MASK_ALL;
		blink_ms = csw_pkg::BLINK_RST;
		anim_ms = csw_pkg::ANIM_RST;
		reset_screen = '0;
		reset_screen.phase = csw_pkg::PH_BOOT;
		reset_screen.digit_visible = csw_pkg::MASK_ALL;
		reset_screen.anim_frame = csw_pkg::FRAME_LAST;

		// boot animation: reset screen, unused code, period edges, wrapped time
		add_word(csw_pkg::FN_TICK, 32'd0, 1'b0, 1'b0, 1'b1);
		add_word(3'd7, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
		add_word(csw_pkg::FN_TICK, 32'd83, 1'b0, 1'b0, 1'b0);
		add_word(csw_pkg::FN_TICK, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
		add_write(csw_pkg::CFG_ANIM, 16'd1);
		add_word(csw_pkg::FN_TICK, 32'd0, 1'b0, 1'b0, 1'b0);
		add_write(csw_pkg::CFG_ANIM, 16'd0);
		add_word(csw_pkg::FN_TICK, 32'd0, 1'b0, 1'b0, 1'b0);
		add_write(csw_pkg::CFG_ANIM, 16'hFFFF);
		add_word(csw_pkg::FN_TICK, 32'd65535, 1'b0, 1'b0, 1'b0);
		// buttons without an action in boot only beep
		add_word(csw_pkg::FN_ENC, 32'd0, 1'b1, 1'b0, 1'b0);
		add_word(csw_pkg::FN_TOP, 32'd0, 1'b0, 1'b0, 1'b0);
		add_word(csw_pkg::FN_BACK, 32'd0, 1'b0, 1'b0, 1'b0);
		// hello with the longest blink period
		add_word(csw_pkg::FN_INIT, 32'd0, 1'b0, 1'b0, 1'b0);
		add_write(csw_pkg::CFG_BLINK, 16'hFFFF);
		add_word(csw_pkg::FN_TICK, 32'd131070, 1'b0, 1'b0, 1'b0);
		add_word(csw_pkg::FN_TICK, 32'd131071, 1'b0, 1'b0, 1'b0);
		add_write(csw_pkg::CFG_BLINK, csw_pkg::BLINK_RST);
		add_write(csw_pkg::CFG_ANIM, csw_pkg::ANIM_RST);
		// year down to a leap year, day and month wraps, day clamp
		add_word(csw_pkg::FN_TOP, 32'd0, 1'b0, 1'b0, 1'b0);
		add_word(csw_pkg::FN_ENC, 32'd0, 1'b0, 1'b0, 1'b0);
		add_word(csw_pkg::FN_TOP, 32'd0, 1'b0, 1'b0, 1'b0);
		add_word(csw_pkg::FN_ENC, 32'd0, 1'b0, 1'b0, 1'b0);
		add_word(csw_pkg::FN_BACK, 32'd0, 1'b0, 1'b0, 1'b0);
		add_word(csw_pkg::FN_ENC, 32'd0, 1'b0, 1'b0, 1'b0);
		add_word(csw_pkg::FN_ENC, 32'd0, 1'b0, 1'b0, 1'b0);
		add_word(csw_pkg::FN_TICK, 32'd131371, 1'b0, 1'b0, 1'b0);
		// hour and minute wraps, commit, re-init of a configured clock
		add_word(csw_pkg::FN_TOP, 32'd0, 1'b0, 1'b0, 1'b0);
		add_word(csw_pkg::FN_ENC, 32'd0, 1'b0, 1'b0, 1'b0);
		add_word(csw_pkg::FN_BACK, 32'd0, 1'b0, 1'b0, 1'b0);
		add_word(csw_pkg::FN_ENC, 32'd0, 1'b0, 1'b0, 1'b0);
		add_word(csw_pkg::FN_TOP, 32'd0, 1'b0, 1'b0, 1'b0);
		add_word(csw_pkg::FN_INIT, 32'd0, 1'b0, 1'b1, 1'b0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < directed_rows.size(); i++) begin
			rw = directed_rows[i];
			if (rw.is_cfg) write_reg(rw.cfg_idx, rw.cfg_val);
			else offer_word(rw.ev, rw.at_reset);
		end

		// random sessions under several period settings
		for (int p = 0; p < 5; p++) begin
			case (p)
				0: begin
					write_reg(csw_pkg::CFG_BLINK, 16'd1);
					write_reg(csw_pkg::CFG_ANIM, 16'd1);
				end
				1: begin
					write_reg(csw_pkg::CFG_BLINK, 16'hFFFF);
					write_reg(csw_pkg::CFG_ANIM, 16'hFFFF);
				end
				2: begin
					write_reg(csw_pkg::CFG_BLINK, 16'd0);
					write_reg(csw_pkg::CFG_ANIM, 16'd0);
				end
				3: begin
					write_reg(csw_pkg::CFG_BLINK, 16'($urandom_range(1, 600)));
					write_reg(csw_pkg::CFG_ANIM, 16'($urandom_range(1, 600)));
				end
				default: begin
					write_reg(csw_pkg::CFG_BLINK, csw_pkg::BLINK_RST);
					write_reg(csw_pkg::CFG_ANIM, csw_pkg::ANIM_RST);
				end
			endcase
			useful = 0;
			while (useful < WORDS_PER_SETTING) begin
				pick_event(ev);
				if (!(ev.func > csw_pkg::FN_INIT ||
						(wiz.phase == csw_pkg::PH_DONE && ev.func != csw_pkg::FN_INIT)))
					useful++;
				offer_word(ev, 1'b0);
			end
		end

		// drain and let the pipeline settle
		in_valid <= 1'b0;
		while (pending_screens.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("PASS clock_setup_wizard_fsm_unit");
		end else begin
			$display("FAIL clock_setup_wizard_fsm_unit");
		end
		$finish;
	end

endmodule
